// ===== src/pkrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkrt_pkg: shared types and constants for the per-key run tracker
// Item layouts, controller commands and status, and state encoding.
// ----------------------------------------------------------------------------
package pkrt_pkg;

    localparam int ENTRIES_DEF  = 64;
    localparam int KEY_BITS_DEF = 32;
    localparam int RUN_BITS_DEF = 48;

    localparam int KEY_IN_W  = 32;
    localparam int BLK_W     = 32;
    localparam int BCNT_W    = 16;
    localparam int OUT_RUN_W = 48;

    typedef struct packed {
        logic [KEY_IN_W-1:0] stream_key;
        logic [BLK_W-1:0]    start_block;
        logic [BCNT_W-1:0]   block_count;
        logic                is_read;
    } t_in;

    typedef struct packed {
        logic                 seq_hit;
        logic [OUT_RUN_W-1:0] ended_run;
        logic                 table_full;
    } t_out;

    typedef struct packed {
        logic load;
        logic scan;
        logic alloc;
        logic fetch;
        logic write;
    } t_cmd;

    typedef struct packed {
        logic match;
        logic miss;
        logic full;
        logic out_free;
    } t_sts;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_ALLOC = 5'b00100,
        ST_FETCH = 5'b01000,
        ST_WRITE = 5'b10000
    } t_state;

endpackage

// ===== src/pkrt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkrt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module pkrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pkrt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkrt_ctrl: item sequencer
// Steps one item through key scan, then allocation or entry fetch as needed, and write-back.
// ----------------------------------------------------------------------------
module pkrt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pkrt_pkg::t_sts i_sts,
    output pkrt_pkg::t_cmd o_cmd
);

    import pkrt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.match) begin
                    n_state = ST_FETCH;
                end else if (i_sts.miss) begin
                    n_state = i_sts.full ? ST_WRITE : ST_ALLOC;
                end
            end
            ST_ALLOC: begin
                o_cmd.alloc = 1'b1;
                n_state     = ST_WRITE;
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_WRITE;
            end
            ST_WRITE: begin
                if (i_sts.out_free) begin
                    o_cmd.write = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/pkrt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkrt_dp: run tracker datapath
// Key table scan, entry allocation, run update and the result register.
// ----------------------------------------------------------------------------
module pkrt_dp #(
    parameter int ENTRIES  = pkrt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = pkrt_pkg::KEY_BITS_DEF,
    parameter int RUN_BITS = pkrt_pkg::RUN_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pkrt_pkg::t_cmd i_cmd,
    output pkrt_pkg::t_sts o_sts,
    input  pkrt_pkg::t_in  i_in_data,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output pkrt_pkg::t_out o_out_data
);

    import pkrt_pkg::*;

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int FILL_W  = $clog2(ENTRIES + 1);
    localparam int DATA_W  = 1 + BLK_W + RUN_BITS;
    localparam int DDEPTH  = 2 * ENTRIES;
    localparam int DADDR_W = IDX_W + 1;

    t_in               r_item;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_scan;
    logic              r_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic [IDX_W-1:0]  r_hit_idx;
    logic              r_full;
    logic              r_fresh;
    logic              r_out_vld;
    t_out              r_out;

    logic [KEY_BITS-1:0] w_key;
    logic [KEY_BITS-1:0] w_key_q;
    logic                w_issue;
    logic                w_match;
    logic                w_miss;
    logic                w_tbl_full;
    logic                w_out_free;

    logic                d_we;
    logic [DADDR_W-1:0]  d_waddr;
    logic [DATA_W-1:0]   d_wdata;
    logic [DADDR_W-1:0]  d_raddr;
    logic [DATA_W-1:0]   d_rdata;

    logic                q_ok;
    logic [BLK_W-1:0]    q_end;
    logic [RUN_BITS-1:0] q_run;
    logic                w_seq;
    logic [RUN_BITS-1:0] w_base;
    logic [RUN_BITS:0]   w_sum;
    logic [RUN_BITS-1:0] w_new_run;
    logic [BLK_W-1:0]    w_new_end;
    t_out                w_res;

    assign w_key      = KEY_BITS'(r_item.stream_key);
    assign w_issue    = i_cmd.scan && (r_scan != r_fill);
    assign w_match    = r_cmp_vld && (w_key_q == w_key);
    assign w_miss     = (r_scan == r_fill) && !r_cmp_vld;
    assign w_tbl_full = (r_fill == FILL_W'(ENTRIES));
    assign w_out_free = !r_out_vld || !i_out_stall;

    assign o_sts.match    = w_match;
    assign o_sts.miss     = w_miss;
    assign o_sts.full     = w_tbl_full;
    assign o_sts.out_free = w_out_free;

    pkrt_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.alloc),
        .i_waddr (r_fill[IDX_W-1:0]),
        .i_wdata (w_key),
        .i_re    (w_issue),
        .i_raddr (r_scan[IDX_W-1:0]),
        .o_rdata (w_key_q)
    );

    pkrt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DDEPTH)
    ) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_re    (i_cmd.fetch),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    always_comb begin
        q_ok  = 1'b0;
        q_end = '0;
        q_run = '0;
        if (!r_fresh) begin
            {q_ok, q_end, q_run} = d_rdata;
        end
        w_seq     = q_ok && (r_item.start_block == (q_end + BLK_W'(1)));
        w_base    = w_seq ? q_run : '0;
        w_sum     = {1'b0, w_base} + (RUN_BITS + 1)'(r_item.block_count);
        w_new_run = w_sum[RUN_BITS] ? '1 : w_sum[RUN_BITS-1:0];
        w_new_end = r_item.start_block + BLK_W'(r_item.block_count) - BLK_W'(1);

        w_res = '0;
        if (r_full) begin
            w_res.table_full = 1'b1;
        end else begin
            w_res.seq_hit   = w_seq;
            w_res.ended_run = w_seq ? '0 : OUT_RUN_W'(q_run);
        end
    end

    // other direction of a new entry is cleared at allocation
    assign d_raddr = {r_hit_idx, r_item.is_read};
    assign d_we    = i_cmd.alloc || (i_cmd.write && !r_full);
    assign d_waddr = i_cmd.alloc ? {r_fill[IDX_W-1:0], !r_item.is_read} : d_raddr;
    assign d_wdata = i_cmd.alloc ? '0 : {1'b1, w_new_end, w_new_run};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_scan    <= '0;
            r_cmp_vld <= 1'b0;
            r_full    <= 1'b0;
            r_fresh   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_scan    <= '0;
                r_cmp_vld <= 1'b0;
                r_full    <= 1'b0;
                r_fresh   <= 1'b0;
            end else begin
                r_cmp_vld <= w_issue;
                if (w_issue) begin
                    r_scan <= r_scan + FILL_W'(1);
                end
                if (i_cmd.scan && !w_match && w_miss) begin
                    r_full <= w_tbl_full;
                end
                if (i_cmd.alloc) begin
                    r_fresh <= 1'b1;
                    r_fill  <= r_fill + FILL_W'(1);
                end
            end
            if (i_cmd.write) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (w_issue) begin
            r_cmp_idx <= r_scan[IDX_W-1:0];
        end
        if (i_cmd.scan && w_match) begin
            r_hit_idx <= r_cmp_idx;
        end else if (i_cmd.alloc) begin
            r_hit_idx <= r_fill[IDX_W-1:0];
        end
        if (i_cmd.write) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== src/per_key_sequential_run_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_key_sequential_run_tracker: per-key sequential run tracker
// Looks up a stream key, extends or restarts the read or write run of the
// entry and reports whether the access was sequential.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+--------------------------
//   in       | input     | i_in_valid/o_in_stall | i_in_data (t_in)
//   out      | output    | o_out_valid/i_out_stall | o_out_data (t_out)
//
// One item at a time. A key hit scans the key table up to the matching entry,
// then fetches the entry's run and writes it back; a miss scans all F entries
// in use, allocates an entry unless the table is full, and writes back.
// The key scan reads one key RAM entry per cycle.
// Reset clears the fill count; there is no clearing pass.
// A result waits in the output register while out is stalled; the next item
// is still accepted and held at write-back until the register frees.
// ----------------------------------------------------------------------------
module per_key_sequential_run_tracker #(
    parameter int ENTRIES  = pkrt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = pkrt_pkg::KEY_BITS_DEF,
    parameter int RUN_BITS = pkrt_pkg::RUN_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  pkrt_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output pkrt_pkg::t_out o_out_data
);

    import pkrt_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    pkrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pkrt_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS),
        .RUN_BITS (RUN_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== src/pkrt_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkrt_chk: port checker for the run tracker
// Watches the top-level ports for result consistency and handshake rules.
// ----------------------------------------------------------------------------
module pkrt_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input pkrt_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input pkrt_pkg::t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("out valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("out item changed while stalled");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.table_full |->
            !o_out_data.seq_hit && (o_out_data.ended_run == '0))
        else $error("table full item carries run data");

    a_seq_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.seq_hit |-> (o_out_data.ended_run == '0))
        else $error("sequential item reports a completed run");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted while one is in work");

endmodule

bind per_key_sequential_run_tracker pkrt_chk u_pkrt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
